// ===== hw/rtl/sacts_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and a helper function of the cache tag store.
package sacts_pkg;

   // Fixed field widths of the request and response ports
   localparam int ADDR_W    = 32;
   localparam int WAY_OUT_W = 2;

   // Default cache geometry
   localparam int DEF_CAPACITY_BYTES = 8192;
   localparam int DEF_BLOCK_BYTES    = 32;
   localparam int DEF_WAYS           = 4;
   localparam int DEF_ADDRESS_BITS   = 32;

   // Access kinds carried on req_mode
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_STORE = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;   // write one set of the clearing pass
      logic lookup;  // capture a request and launch the RAM read
      logic commit;  // resolve the lookup, update the RAMs and load the response
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last set
   } status_type;

   // Floor of log2, evaluated at elaboration
   function automatic int floor_log2(input longint unsigned v);
      longint unsigned x;
      int              n;
      x = v;
      n = 0;
      while (x > 1) begin
         x = x >> 1;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/sacts_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sacts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sacts_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the cache tag store: clearing pass, lookup and response handshake.
module sacts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sacts_pkg::status_type status,
   output sacts_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // Response slot can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Decode commands from the current state
   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.lookup = (state_ff == ST_IDLE) && req_valid;
      cmd.commit = (state_ff == ST_READ) && out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Load the response on commit, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/sacts_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the cache tag store: per-way tag RAMs, victim pointer RAM, compare and response registers.
module sacts_dp #(
   parameter int CAPACITY_BYTES = sacts_pkg::DEF_CAPACITY_BYTES,
   parameter int BLOCK_BYTES    = sacts_pkg::DEF_BLOCK_BYTES,
   parameter int WAYS           = sacts_pkg::DEF_WAYS,
   parameter int ADDRESS_BITS   = sacts_pkg::DEF_ADDRESS_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sacts_pkg::cmd_type                cmd,
   output sacts_pkg::status_type             status,
   input  logic [sacts_pkg::ADDR_W-1:0]      req_address,
   input  logic                              req_mode,
   output logic                              rsp_hit,
   output logic                              rsp_writeback,
   output logic [sacts_pkg::WAY_OUT_W-1:0]   rsp_way
);

   // Geometry
   localparam int RAW_SETS  = CAPACITY_BYTES / (BLOCK_BYTES * WAYS);
   localparam int SETS      = (RAW_SETS > 0) ? RAW_SETS : 1;
   localparam int OFF_BITS  = sacts_pkg::floor_log2(longint'(BLOCK_BYTES));
   localparam int IDX_BITS  = sacts_pkg::floor_log2(longint'(SETS));
   localparam int TAG_BITS  = (ADDRESS_BITS > OFF_BITS + IDX_BITS) ?
                              (ADDRESS_BITS - OFF_BITS - IDX_BITS) : 0;
   localparam int IDX_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
   localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int SET_AW    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int PTR_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_W    = TAG_W + 2;
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << IDX_BITS) - 64'd1);
   localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 64'd1);
   localparam logic [PTR_W-1:0] LAST_WAY = PTR_W'(WAYS - 1);
   localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(SETS - 1);

   logic [ADDRESS_BITS-1:0] addr_ext;
   logic [IDX_W-1:0]        req_set;
   logic [TAG_W-1:0]        req_tag;

   logic [SET_AW-1:0]       set_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic                    store_ff;
   logic [SET_AW-1:0]       clr_cnt_ff;
   logic [SET_AW-1:0]       clr_cnt_in;

   logic [SET_AW-1:0]       rd_addr;
   logic [SET_AW-1:0]       wr_addr;

   logic [LINE_W-1:0]       line_rd [WAYS];
   logic [WAYS-1:0]         way_valid;
   logic [WAYS-1:0]         way_dirty;
   logic [WAYS-1:0]         way_match;
   logic [WAYS-1:0]         line_we;
   logic [LINE_W-1:0]       line_wr;

   logic [PTR_W-1:0]        ptr_rd;
   logic [PTR_W-1:0]        ptr_wr;
   logic                    ptr_we;

   logic                    hit;
   logic [PTR_W-1:0]        hit_way;
   logic [PTR_W-1:0]        chosen;
   logic                    wb;
   logic                    new_dirty;

   logic                    rsp_hit_ff;
   logic                    rsp_writeback_ff;
   logic [sacts_pkg::WAY_OUT_W-1:0] rsp_way_ff;

   // Split the address into set index and tag
   assign addr_ext = ADDRESS_BITS'(req_address);
   assign req_set  = IDX_W'(addr_ext >> OFF_BITS) & IDX_MASK;
   assign req_tag  = TAG_W'(addr_ext >> (OFF_BITS + IDX_BITS)) & TAG_MASK;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         set_ff   <= SET_AW'(req_set);
         tag_ff   <= req_tag;
         store_ff <= (req_mode == sacts_pkg::MODE_STORE);
      end
   end

   // Advance the clearing pass counter
   assign clr_cnt_in = (clr_cnt_ff == LAST_SET) ? '0 : clr_cnt_ff + SET_AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign status.clear_last = (clr_cnt_ff == LAST_SET);

   // Read the set of a new request, otherwise hold the captured set
   assign rd_addr = cmd.lookup ? SET_AW'(req_set) : set_ff;
   assign wr_addr = cmd.clear ? clr_cnt_ff : set_ff;

   // One tag RAM per way, entry is {valid, dirty, tag}
   for (genvar w = 0; w < WAYS; w++) begin : g_way
      sacts_ram #(
         .WIDTH (LINE_W),
         .DEPTH (SETS),
         .AW    (SET_AW)
      ) u_line_ram (
         .clock   (clock),
         .wr_en   (line_we[w]),
         .wr_addr (wr_addr),
         .wr_data (line_wr),
         .rd_addr (rd_addr),
         .rd_data (line_rd[w])
      );

      assign way_valid[w] = line_rd[w][LINE_W-1];
      assign way_dirty[w] = line_rd[w][LINE_W-2];
      assign way_match[w] = way_valid[w] && (line_rd[w][TAG_W-1:0] == tag_ff);
      assign line_we[w]   = cmd.clear || (cmd.commit && (chosen == PTR_W'(w)));
   end

   // Round-robin victim pointer, one entry per set
   sacts_ram #(
      .WIDTH (PTR_W),
      .DEPTH (SETS),
      .AW    (SET_AW)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_we),
      .wr_addr (wr_addr),
      .wr_data (ptr_wr),
      .rd_addr (rd_addr),
      .rd_data (ptr_rd)
   );

   // Lowest matching way wins
   always_comb begin
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_match[w]) begin
            hit_way = PTR_W'(w);
         end
      end
   end

   assign hit       = |way_match;
   assign chosen    = hit ? hit_way : ptr_rd;
   assign wb        = !hit && way_valid[ptr_rd] && way_dirty[ptr_rd];
   assign new_dirty = store_ff || (hit && way_dirty[hit_way]);

   // Line and pointer write data; clearing writes zero
   assign line_wr = cmd.clear ? '0 : {1'b1, new_dirty, tag_ff};
   assign ptr_we  = cmd.clear || cmd.commit;
   assign ptr_wr  = (cmd.clear || (chosen == LAST_WAY)) ? '0 : chosen + PTR_W'(1);

   // Load the response registers
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff       <= hit;
         rsp_writeback_ff <= wb;
         rsp_way_ff       <= sacts_pkg::WAY_OUT_W'(chosen);
      end
   end

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_writeback = rsp_writeback_ff;
   assign rsp_way       = rsp_way_ff;

endmodule

// ===== hw/rtl/set_assoc_cache_tag_store.sv =====
`timescale 1ns / 1ps
// Top level of the set-associative cache tag store with round-robin replacement.
// An accepted request is captured with the tag RAM read; its result is then registered in the
// response register once that slot is free, and only then is a new request accepted.
// The response register lets the next request be accepted while a response waits.
// Reset: a clearing pass writes every set of the tag and pointer RAMs, one set per cycle
// (CAPACITY_BYTES / (BLOCK_BYTES * WAYS) sets, 64 by default); req_ready stays low meanwhile.
module set_assoc_cache_tag_store #(
   parameter int CAPACITY_BYTES = sacts_pkg::DEF_CAPACITY_BYTES,
   parameter int BLOCK_BYTES    = sacts_pkg::DEF_BLOCK_BYTES,
   parameter int WAYS           = sacts_pkg::DEF_WAYS,
   parameter int ADDRESS_BITS   = sacts_pkg::DEF_ADDRESS_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sacts_pkg::ADDR_W-1:0]    req_address,
   input  logic                            req_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic                            rsp_writeback,
   output logic [sacts_pkg::WAY_OUT_W-1:0] rsp_way
);

   sacts_pkg::cmd_type    cmd;
   sacts_pkg::status_type status;

   // Controller
   sacts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   sacts_dp #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .BLOCK_BYTES    (BLOCK_BYTES),
      .WAYS           (WAYS),
      .ADDRESS_BITS   (ADDRESS_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_address   (req_address),
      .req_mode      (req_mode),
      .rsp_hit       (rsp_hit),
      .rsp_writeback (rsp_writeback),
      .rsp_way       (rsp_way)
   );

endmodule
